// ===== rtl/core/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands used by the core datapath.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/core/pidpmc_pkg.sv =====
// ----------------------------------------------------------------------------
// pidpmc_pkg
// Types, widths, codes and helpers of the PID position motor controller.
// ----------------------------------------------------------------------------
`default_nettype none

package pidpmc_pkg;

   localparam int POS_BITS       = 24;
   localparam int VALUE_BITS     = 24;
   localparam int FUNC_BITS      = 3;
   localparam int ERR_BITS       = POS_BITS + 1;
   localparam int DIFF_BITS      = POS_BITS + 2;
   localparam int GAIN_BITS      = 16;
   localparam int MUL_B_BITS     = GAIN_BITS + 1;
   localparam int PROD_BITS      = DIFF_BITS + MUL_B_BITS;
   localparam int ACC_BITS       = PROD_BITS + 2;
   localparam int ESUM_BITS      = 12;
   localparam int SPEED_BITS     = 9;
   localparam int DELTA_BITS     = SPEED_BITS + 1;
   localparam int NUM_BITS       = 12;
   localparam int PWM_BITS       = 8;
   localparam int FRAC_BITS      = 12;
   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 16;

   localparam int ISUM_LIMIT  = 2000;
   localparam int FRICTION    = 7;
   localparam int SETTLE_BAND = 10;
   localparam int SLEW_LIMIT  = 50;

   // reciprocal of five, exact for magnitudes below 2048
   localparam int DIV5_MUL   = 1639;
   localparam int DIV5_SHIFT = 13;

   localparam logic [PWM_BITS-1:0]  MAX_SPEED_RESET = 8'd255;
   localparam logic [GAIN_BITS-1:0] GAIN_P_RESET    = 16'd614;
   localparam logic [GAIN_BITS-1:0] GAIN_I_RESET    = 16'd123;
   localparam logic [GAIN_BITS-1:0] GAIN_D_RESET    = 16'd2048;

   typedef logic signed [POS_BITS-1:0]   pos_type;
   typedef logic signed [VALUE_BITS-1:0] value_type;
   typedef logic signed [ERR_BITS-1:0]   err_type;
   typedef logic signed [DIFF_BITS-1:0]  diff_type;
   typedef logic signed [MUL_B_BITS-1:0] mul_b_type;
   typedef logic signed [PROD_BITS-1:0]  prod_type;
   typedef logic signed [ACC_BITS-1:0]   acc_type;
   typedef logic signed [ESUM_BITS-1:0]  esum_type;
   typedef logic signed [SPEED_BITS-1:0] speed_type;
   typedef logic signed [DELTA_BITS-1:0] delta_type;
   typedef logic signed [NUM_BITS-1:0]   num_type;

   localparam acc_type FRICTION_Q = acc_type'(FRICTION * (2 ** FRAC_BITS));

   typedef enum logic [FUNC_BITS-1:0] {
      FUNC_TICK         = 3'd0,
      FUNC_EDGE_A       = 3'd1,
      FUNC_EDGE_B       = 3'd2,
      FUNC_SET_TARGET   = 3'd3,
      FUNC_SET_SPEED    = 3'd4,
      FUNC_SET_POSITION = 3'd5
   } func_type;

   typedef enum logic [1:0] {
      MODE_IDLE   = 2'd0,
      MODE_TARGET = 2'd1,
      MODE_SPEED  = 2'd2
   } mode_type;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_MAX_SPEED = 3'd0,
      CSR_INVERT    = 3'd1,
      CSR_GAIN_P    = 3'd2,
      CSR_GAIN_I    = 3'd3,
      CSR_GAIN_D    = 3'd4
   } csr_index_type;

   typedef enum logic [3:0] {
      CS_IDLE,
      CS_EXEC,
      CS_CHECK,
      CS_MUL_P,
      CS_MUL_I,
      CS_MUL_D,
      CS_SUM,
      CS_FRIC,
      CS_CMD,
      CS_SLEW,
      CS_EMIT
   } ctrl_state_type;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_CAPTURE,
      OP_EXEC,
      OP_CHECK,
      OP_MUL_P,
      OP_MUL_I,
      OP_MUL_D,
      OP_SUM,
      OP_FRIC,
      OP_CMD,
      OP_SLEW,
      OP_EMIT
   } dp_op_type;

   typedef struct packed {
      dp_op_type op;
   } dp_cmd_type;

   typedef struct packed {
      logic tick_target;
      logic settled;
      logic out_free;
   } dp_status_type;

   // divide by five, truncating toward zero
   function automatic num_type div5_trunc(input num_type num);
      logic [NUM_BITS-2:0]            mag;
      logic [2*(NUM_BITS-1)-1:0]      prod;
      num_type                        quo;
      mag  = (num < 0) ? (NUM_BITS-1)'(-num) : (NUM_BITS-1)'(num);
      prod = (2*(NUM_BITS-1))'(mag) * (2*(NUM_BITS-1))'(DIV5_MUL);
      quo  = num_type'(prod >> DIV5_SHIFT);
      return (num < 0) ? -quo : quo;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/core/pidpmc_req_if.sv =====
// ----------------------------------------------------------------------------
// pidpmc_req_if
// Event channel into the controller core.
// ----------------------------------------------------------------------------
`default_nettype none

interface pidpmc_req_if;
   logic                                valid;
   logic                                ready;
   logic [pidpmc_pkg::FUNC_BITS-1:0]    func;
   pidpmc_pkg::value_type               value;
   logic                                other_level;

   modport source (output valid, func, value, other_level, input ready);
   modport sink   (input valid, func, value, other_level, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/pidpmc_rsp_if.sv =====
// ----------------------------------------------------------------------------
// pidpmc_rsp_if
// Status channel out of the controller core.
// ----------------------------------------------------------------------------
`default_nettype none

interface pidpmc_rsp_if;
   logic                               valid;
   logic                               ready;
   logic [pidpmc_pkg::PWM_BITS-1:0]    pwm_duty;
   logic                               direction;
   logic                               running;
   pidpmc_pkg::value_type              position_now;

   modport source (output valid, pwm_duty, direction, running, position_now, input ready);
   modport sink   (input valid, pwm_duty, direction, running, position_now, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/pidpmc_ctrl.sv =====
// ----------------------------------------------------------------------------
// pidpmc_ctrl
// Sequencer: steps the datapath through an event and the PID stages.
// ----------------------------------------------------------------------------
`default_nettype none

module pidpmc_ctrl (
   input  wire                         clock,
   input  wire                         reset,
   input  wire                         req_valid,
   output logic                        req_ready,
   input  pidpmc_pkg::dp_status_type   status,
   output pidpmc_pkg::dp_cmd_type      cmd
);

   pidpmc_pkg::ctrl_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= pidpmc_pkg::CS_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd.op    = pidpmc_pkg::OP_NONE;
      req_ready = 1'b0;
      case (state_ff)
         pidpmc_pkg::CS_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.op   = pidpmc_pkg::OP_CAPTURE;
               state_in = pidpmc_pkg::CS_EXEC;
            end
         end
         pidpmc_pkg::CS_EXEC: begin
            cmd.op   = pidpmc_pkg::OP_EXEC;
            state_in = status.tick_target ? pidpmc_pkg::CS_CHECK : pidpmc_pkg::CS_EMIT;
         end
         pidpmc_pkg::CS_CHECK: begin
            cmd.op   = pidpmc_pkg::OP_CHECK;
            state_in = status.settled ? pidpmc_pkg::CS_EMIT : pidpmc_pkg::CS_MUL_P;
         end
         pidpmc_pkg::CS_MUL_P: begin
            cmd.op   = pidpmc_pkg::OP_MUL_P;
            state_in = pidpmc_pkg::CS_MUL_I;
         end
         pidpmc_pkg::CS_MUL_I: begin
            cmd.op   = pidpmc_pkg::OP_MUL_I;
            state_in = pidpmc_pkg::CS_MUL_D;
         end
         pidpmc_pkg::CS_MUL_D: begin
            cmd.op   = pidpmc_pkg::OP_MUL_D;
            state_in = pidpmc_pkg::CS_SUM;
         end
         pidpmc_pkg::CS_SUM: begin
            cmd.op   = pidpmc_pkg::OP_SUM;
            state_in = pidpmc_pkg::CS_FRIC;
         end
         pidpmc_pkg::CS_FRIC: begin
            cmd.op   = pidpmc_pkg::OP_FRIC;
            state_in = pidpmc_pkg::CS_CMD;
         end
         pidpmc_pkg::CS_CMD: begin
            cmd.op   = pidpmc_pkg::OP_CMD;
            state_in = pidpmc_pkg::CS_SLEW;
         end
         pidpmc_pkg::CS_SLEW: begin
            cmd.op   = pidpmc_pkg::OP_SLEW;
            state_in = pidpmc_pkg::CS_EMIT;
         end
         pidpmc_pkg::CS_EMIT: begin
            if (status.out_free) begin
               cmd.op   = pidpmc_pkg::OP_EMIT;
               state_in = pidpmc_pkg::CS_IDLE;
            end
         end
         default: begin
            state_in = pidpmc_pkg::CS_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

// ===== rtl/core/pidpmc_datapath.sv =====
// ----------------------------------------------------------------------------
// pidpmc_datapath
// Motor state, registers, shared PID multiplier and the output register.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module pidpmc_datapath (
   input  wire                                        clock,
   input  wire                                        reset,
   input  pidpmc_pkg::dp_cmd_type                     cmd,
   output pidpmc_pkg::dp_status_type                  status,
   input  wire                                        csr_write_enable,
   input  wire  [pidpmc_pkg::CSR_INDEX_BITS-1:0]      csr_index,
   input  wire  [pidpmc_pkg::CSR_DATA_BITS-1:0]       csr_write_data,
   input  wire  [pidpmc_pkg::FUNC_BITS-1:0]           req_func,
   input  pidpmc_pkg::value_type                      req_value,
   input  wire                                        req_other_level,
   output logic                                       rsp_valid,
   input  wire                                        rsp_ready,
   output logic [pidpmc_pkg::PWM_BITS-1:0]            rsp_pwm_duty,
   output logic                                       rsp_direction,
   output logic                                       rsp_running,
   output pidpmc_pkg::value_type                      rsp_position_now
);

   logic [pidpmc_pkg::PWM_BITS-1:0]  max_speed_ff, max_speed_in;
   logic                             invert_ff, invert_in;
   logic [pidpmc_pkg::GAIN_BITS-1:0] gain_p_ff, gain_p_in;
   logic [pidpmc_pkg::GAIN_BITS-1:0] gain_i_ff, gain_i_in;
   logic [pidpmc_pkg::GAIN_BITS-1:0] gain_d_ff, gain_d_in;

   pidpmc_pkg::func_type             func_ff, func_in;
   pidpmc_pkg::value_type            value_ff, value_in;
   logic                             other_ff, other_in;

   pidpmc_pkg::mode_type             mode_ff, mode_in;
   pidpmc_pkg::pos_type              target_ff, target_in;
   pidpmc_pkg::pos_type              position_ff, position_in;
   pidpmc_pkg::speed_type            speed_ff, speed_in;
   pidpmc_pkg::esum_type             esum_ff, esum_in;
   pidpmc_pkg::err_type              last_err_ff, last_err_in;
   logic                             dir_ff, dir_in;
   logic [pidpmc_pkg::PWM_BITS-1:0]  pwm_ff, pwm_in;

   pidpmc_pkg::err_type              err_ff, err_in;
   pidpmc_pkg::diff_type             diff_ff, diff_in;
   pidpmc_pkg::prod_type             prod_ff, prod_in;
   pidpmc_pkg::acc_type              acc_ff, acc_in;
   logic                             neg_ff, neg_in;
   pidpmc_pkg::speed_type            cmd_ff, cmd_in;

   logic                             rsp_valid_ff, rsp_valid_in;
   logic [pidpmc_pkg::PWM_BITS-1:0]  rsp_pwm_ff, rsp_pwm_in;
   logic                             rsp_dir_ff, rsp_dir_in;
   logic                             rsp_run_ff, rsp_run_in;
   pidpmc_pkg::value_type            rsp_pos_ff, rsp_pos_in;

   pidpmc_pkg::diff_type             mul_a;
   pidpmc_pkg::mul_b_type            mul_b;
   pidpmc_pkg::prod_type             mul_prod;
   logic                             settled;

   function automatic logic dir_of(input pidpmc_pkg::speed_type spd, input logic inv);
      return inv ? (spd < 0) : (spd > 0);
   endfunction

   function automatic logic [pidpmc_pkg::PWM_BITS-1:0] pwm_of(
      input pidpmc_pkg::speed_type spd);
      pidpmc_pkg::speed_type mag;
      mag = (spd < 0) ? -spd : spd;
      return mag[pidpmc_pkg::PWM_BITS-1:0];
   endfunction

   assign settled = (err_ff <= pidpmc_pkg::SETTLE_BAND) && (err_ff >= -pidpmc_pkg::SETTLE_BAND);

   assign status.tick_target = (func_ff == pidpmc_pkg::FUNC_TICK) &&
                               (mode_ff == pidpmc_pkg::MODE_TARGET);
   assign status.settled     = settled;
   assign status.out_free    = !rsp_valid_ff || rsp_ready;

   always_comb begin
      case (cmd.op)
         pidpmc_pkg::OP_MUL_I: begin
            mul_a = pidpmc_pkg::diff_type'(esum_ff);
            mul_b = pidpmc_pkg::mul_b_type'({1'b0, gain_i_ff});
         end
         pidpmc_pkg::OP_MUL_D: begin
            mul_a = diff_ff;
            mul_b = pidpmc_pkg::mul_b_type'({1'b0, gain_d_ff});
         end
         default: begin
            mul_a = pidpmc_pkg::diff_type'(err_ff);
            mul_b = pidpmc_pkg::mul_b_type'({1'b0, gain_p_ff});
         end
      endcase
   end

   assign mul_prod = mul_a * mul_b;

   always_comb begin
      pidpmc_pkg::value_type lim_pos;
      pidpmc_pkg::value_type val_clamp;
      pidpmc_pkg::diff_type  esum_sum;
      pidpmc_pkg::acc_type   mag_full;
      pidpmc_pkg::acc_type   mag_shift;
      logic [pidpmc_pkg::PWM_BITS-1:0] cmd_mag;
      pidpmc_pkg::speed_type cmd_pos;
      pidpmc_pkg::delta_type delta;
      pidpmc_pkg::num_type   spd_n;
      pidpmc_pkg::num_type   dlt_n;
      pidpmc_pkg::num_type   num;
      logic                  step_up;

      max_speed_in = max_speed_ff;
      invert_in    = invert_ff;
      gain_p_in    = gain_p_ff;
      gain_i_in    = gain_i_ff;
      gain_d_in    = gain_d_ff;
      func_in      = func_ff;
      value_in     = value_ff;
      other_in     = other_ff;
      mode_in      = mode_ff;
      target_in    = target_ff;
      position_in  = position_ff;
      speed_in     = speed_ff;
      esum_in      = esum_ff;
      last_err_in  = last_err_ff;
      dir_in       = dir_ff;
      pwm_in       = pwm_ff;
      err_in       = err_ff;
      diff_in      = diff_ff;
      prod_in      = prod_ff;
      acc_in       = acc_ff;
      neg_in       = neg_ff;
      cmd_in       = cmd_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_pwm_in   = rsp_pwm_ff;
      rsp_dir_in   = rsp_dir_ff;
      rsp_run_in   = rsp_run_ff;
      rsp_pos_in   = rsp_pos_ff;

      lim_pos   = pidpmc_pkg::value_type'({1'b0, max_speed_ff});
      val_clamp = value_ff;
      esum_sum  = pidpmc_pkg::diff_type'(err_ff) + pidpmc_pkg::diff_type'(esum_ff);
      mag_full  = neg_ff ? -acc_ff : acc_ff;
      mag_shift = mag_full >>> pidpmc_pkg::FRAC_BITS;
      cmd_mag   = (mag_shift > pidpmc_pkg::acc_type'({1'b0, max_speed_ff})) ?
                  max_speed_ff : mag_shift[pidpmc_pkg::PWM_BITS-1:0];
      cmd_pos   = pidpmc_pkg::speed_type'({1'b0, cmd_mag});
      delta     = pidpmc_pkg::delta_type'(cmd_ff) - pidpmc_pkg::delta_type'(speed_ff);
      spd_n     = pidpmc_pkg::num_type'(speed_ff);
      dlt_n     = pidpmc_pkg::num_type'(delta);
      num       = (spd_n <<< 2) + spd_n + (dlt_n <<< 1);
      step_up   = (func_ff == pidpmc_pkg::FUNC_EDGE_A) ? (other_ff ^ invert_ff) :
                  !(other_ff ^ invert_ff);

      if (csr_write_enable) begin
         case (csr_index)
            pidpmc_pkg::CSR_MAX_SPEED: max_speed_in = csr_write_data[pidpmc_pkg::PWM_BITS-1:0];
            pidpmc_pkg::CSR_INVERT:    invert_in    = csr_write_data[0];
            pidpmc_pkg::CSR_GAIN_P:    gain_p_in    = csr_write_data;
            pidpmc_pkg::CSR_GAIN_I:    gain_i_in    = csr_write_data;
            pidpmc_pkg::CSR_GAIN_D:    gain_d_in    = csr_write_data;
            default: begin
            end
         endcase
      end

      case (cmd.op)
         pidpmc_pkg::OP_CAPTURE: begin
            func_in  = pidpmc_pkg::func_type'(req_func);
            value_in = req_value;
            other_in = req_other_level;
         end
         pidpmc_pkg::OP_EXEC: begin
            case (func_ff)
               pidpmc_pkg::FUNC_TICK: begin
                  err_in = pidpmc_pkg::err_type'(target_ff) - pidpmc_pkg::err_type'(position_ff);
               end
               pidpmc_pkg::FUNC_EDGE_A, pidpmc_pkg::FUNC_EDGE_B: begin
                  position_in = step_up ? position_ff + pidpmc_pkg::pos_type'(1) :
                                          position_ff - pidpmc_pkg::pos_type'(1);
               end
               pidpmc_pkg::FUNC_SET_TARGET: begin
                  mode_in   = pidpmc_pkg::MODE_TARGET;
                  target_in = pidpmc_pkg::pos_type'(value_ff);
               end
               pidpmc_pkg::FUNC_SET_SPEED: begin
                  if (value_ff > lim_pos) begin
                     val_clamp = lim_pos;
                  end else if (value_ff < -lim_pos) begin
                     val_clamp = -lim_pos;
                  end
                  speed_in = pidpmc_pkg::speed_type'(val_clamp);
                  mode_in  = (val_clamp != 0) ? pidpmc_pkg::MODE_SPEED : pidpmc_pkg::MODE_IDLE;
                  dir_in   = dir_of(speed_in, invert_ff);
                  pwm_in   = pwm_of(speed_in);
               end
               pidpmc_pkg::FUNC_SET_POSITION: begin
                  position_in = pidpmc_pkg::pos_type'(value_ff);
               end
               default: begin
               end
            endcase
         end
         pidpmc_pkg::OP_CHECK: begin
            if (settled) begin
               mode_in = pidpmc_pkg::MODE_IDLE;
               pwm_in  = '0;
            end else begin
               if (esum_sum > pidpmc_pkg::ISUM_LIMIT) begin
                  esum_in = pidpmc_pkg::esum_type'(pidpmc_pkg::ISUM_LIMIT);
               end else if (esum_sum < -pidpmc_pkg::ISUM_LIMIT) begin
                  esum_in = pidpmc_pkg::esum_type'(-pidpmc_pkg::ISUM_LIMIT);
               end else begin
                  esum_in = pidpmc_pkg::esum_type'(esum_sum);
               end
               diff_in     = pidpmc_pkg::diff_type'(err_ff) - pidpmc_pkg::diff_type'(last_err_ff);
               last_err_in = err_ff;
            end
         end
         pidpmc_pkg::OP_MUL_P: begin
            prod_in = mul_prod;
         end
         pidpmc_pkg::OP_MUL_I: begin
            prod_in = mul_prod;
            acc_in  = pidpmc_pkg::acc_type'(prod_ff);
         end
         pidpmc_pkg::OP_MUL_D: begin
            prod_in = mul_prod;
            acc_in  = acc_ff + pidpmc_pkg::acc_type'(prod_ff);
         end
         pidpmc_pkg::OP_SUM: begin
            acc_in = acc_ff + pidpmc_pkg::acc_type'(prod_ff);
         end
         pidpmc_pkg::OP_FRIC: begin
            if (acc_ff > 0) begin
               acc_in = acc_ff + pidpmc_pkg::FRICTION_Q;
               neg_in = 1'b0;
            end else begin
               acc_in = acc_ff - pidpmc_pkg::FRICTION_Q;
               neg_in = 1'b1;
            end
         end
         pidpmc_pkg::OP_CMD: begin
            cmd_in = neg_ff ? -cmd_pos : cmd_pos;
         end
         pidpmc_pkg::OP_SLEW: begin
            if ((delta > pidpmc_pkg::SLEW_LIMIT) || (delta < -pidpmc_pkg::SLEW_LIMIT)) begin
               speed_in = pidpmc_pkg::speed_type'(pidpmc_pkg::div5_trunc(num));
            end else begin
               speed_in = cmd_ff;
            end
            dir_in = dir_of(speed_in, invert_ff);
            pwm_in = pwm_of(speed_in);
         end
         pidpmc_pkg::OP_EMIT: begin
            rsp_valid_in = 1'b1;
            rsp_pwm_in   = pwm_ff;
            rsp_dir_in   = dir_ff;
            rsp_run_in   = (mode_ff != pidpmc_pkg::MODE_IDLE);
            rsp_pos_in   = pidpmc_pkg::value_type'(position_ff);
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_speed_ff <= pidpmc_pkg::MAX_SPEED_RESET;
         invert_ff    <= 1'b0;
         gain_p_ff    <= pidpmc_pkg::GAIN_P_RESET;
         gain_i_ff    <= pidpmc_pkg::GAIN_I_RESET;
         gain_d_ff    <= pidpmc_pkg::GAIN_D_RESET;
         mode_ff      <= pidpmc_pkg::MODE_IDLE;
         target_ff    <= '0;
         position_ff  <= '0;
         speed_ff     <= '0;
         esum_ff      <= '0;
         last_err_ff  <= '0;
         dir_ff       <= 1'b0;
         pwm_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         max_speed_ff <= max_speed_in;
         invert_ff    <= invert_in;
         gain_p_ff    <= gain_p_in;
         gain_i_ff    <= gain_i_in;
         gain_d_ff    <= gain_d_in;
         mode_ff      <= mode_in;
         target_ff    <= target_in;
         position_ff  <= position_in;
         speed_ff     <= speed_in;
         esum_ff      <= esum_in;
         last_err_ff  <= last_err_in;
         dir_ff       <= dir_in;
         pwm_ff       <= pwm_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      func_ff    <= func_in;
      value_ff   <= value_in;
      other_ff   <= other_in;
      err_ff     <= err_in;
      diff_ff    <= diff_in;
      prod_ff    <= prod_in;
      acc_ff     <= acc_in;
      neg_ff     <= neg_in;
      cmd_ff     <= cmd_in;
      rsp_pwm_ff <= rsp_pwm_in;
      rsp_dir_ff <= rsp_dir_in;
      rsp_run_ff <= rsp_run_in;
      rsp_pos_ff <= rsp_pos_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_pwm_duty     = rsp_pwm_ff;
   assign rsp_direction    = rsp_dir_ff;
   assign rsp_running      = rsp_run_ff;
   assign rsp_position_now = rsp_pos_ff;

   `ASSERT_IMPLY(a_esum_range, clock, reset, 1'b1, (esum_ff <= pidpmc_pkg::ISUM_LIMIT && esum_ff >= -pidpmc_pkg::ISUM_LIMIT), "integral left its clamp range")
   `ASSERT_NEXT(a_cmd_limit, clock, reset, cmd.op == pidpmc_pkg::OP_CMD, (cmd_ff <= $signed({1'b0, max_speed_ff}) && cmd_ff >= -$signed({1'b0, max_speed_ff})), "command exceeds max speed")
   `ASSERT_NEXT(a_emit_valid, clock, reset, cmd.op == pidpmc_pkg::OP_EMIT, rsp_valid_ff, "emitted beat not presented")

endmodule

`default_nettype wire

// ===== rtl/core/pid_position_motor_controller_core.sv =====
// ----------------------------------------------------------------------------
// pid_position_motor_controller_core
// Event-driven DC motor position controller with PID and slew limiting.
// ----------------------------------------------------------------------------
// Usage:
//   req_chan carries one event per beat: control tick, encoder A or B edge
//   (with the other channel level), set target, set speed or set position.
//   rsp_chan returns one beat per event: PWM duty, direction, running flag
//   and the position count after the event.
//   csr_* writes the max speed, inversion and Q4.12 gains; write only while
//   no event is in flight.
// Sequencing:
//   Non-tick events and ticks outside target mode step through execute and
//   emit; a tick that settles adds a check step; a full PID tick then runs
//   three products through one shared multiplier, one per cycle, then sum,
//   friction, clamp and slew stages. One event is in work at a time, so a
//   new beat is accepted only once the last one has been emitted.
// Reset: synchronous; registers return to their defaults, the motor state
//   clears to idle, position zero and PWM zero.
// Stall: the result register holds its beat until rsp_chan.ready; a new
//   event is still accepted and waits at its final step for the register.
// ----------------------------------------------------------------------------
`default_nettype none

module pid_position_motor_controller_core (
   input  wire                                     clock,
   input  wire                                     reset,
   pidpmc_req_if.sink                              req_chan,
   pidpmc_rsp_if.source                            rsp_chan,
   input  wire                                     csr_write_enable,
   input  wire  [pidpmc_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  wire  [pidpmc_pkg::CSR_DATA_BITS-1:0]    csr_write_data
);

   pidpmc_pkg::dp_cmd_type    dp_cmd;
   pidpmc_pkg::dp_status_type dp_status;
   logic                      req_ready;

   pidpmc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_ready),
      .status    (dp_status),
      .cmd       (dp_cmd)
   );

   pidpmc_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (dp_cmd),
      .status           (dp_status),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req_func         (req_chan.func),
      .req_value        (req_chan.value),
      .req_other_level  (req_chan.other_level),
      .rsp_valid        (rsp_chan.valid),
      .rsp_ready        (rsp_chan.ready),
      .rsp_pwm_duty     (rsp_chan.pwm_duty),
      .rsp_direction    (rsp_chan.direction),
      .rsp_running      (rsp_chan.running),
      .rsp_position_now (rsp_chan.position_now)
   );

   assign req_chan.ready = req_ready;

endmodule

`default_nettype wire
